// ===== hdl/fjop_pkg.sv =====
package fjop_pkg;

  localparam int unsigned ACC_W = 64;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  // literal words, left justified in five byte slots
  localparam logic [39:0] WORD_TRUE  = {"true", 8'h00};
  localparam logic [39:0] WORD_FALSE = "false";
  localparam logic [39:0] WORD_NULL  = {"null", 8'h00};

  typedef enum logic [3:0] {
    PH_OPEN, PH_FIRST, PH_KEYQ, PH_KEY, PH_COLON,
    PH_VSTART, PH_VSTR, PH_TOKEN, PH_AFTER, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    TC_NONE, TC_TRUE, TC_FALSE, TC_NULL, TC_DIGITS, TC_BAD
  } tok_class_e;

  typedef enum logic [2:0] {
    EV_NONE, EV_KEY_BYTE, EV_STR_BYTE, EV_KEY_END, EV_VALUE_END, EV_ERROR, EV_ACCEPT
  } evt_e;

  typedef enum logic [3:0] {
    ERR_NONE, ERR_MALFORMED, ERR_CONTROL, ERR_BAD_ESCAPE, ERR_TRUNC_ESCAPE,
    ERR_UNTERMINATED, ERR_MISSING_VALUE, ERR_BAD_VALUE, ERR_TRAILING
  } err_e;

  typedef enum logic [1:0] {
    VT_STRING, VT_NUMBER, VT_BOOL, VT_NULL
  } vtype_e;

  typedef enum logic [1:0] {
    TOK_HOLD, TOK_START, TOK_FEED, TOK_CLEAR
  } tok_cmd_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       event_res;
    logic [7:0]       char_out;
    logic [1:0]       value_type;
    logic             bool_value;
    logic [ACC_W-1:0] number_value;
    logic             number_overflow;
    logic             closes_object;
    logic [3:0]       error_code;
  } out_word_t;

  typedef struct packed {
    tok_class_e       cls;
    logic             valid;
    logic [ACC_W-1:0] acc;
    logic             ovf;
  } tok_status_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } esc_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {CH_SPACE, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic esc_t esc_decode(input logic [7:0] c);
    esc_t r;
    r.ok = 1'b1;
    r.ch = c;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: r.ch = c;
      8'h62:   r.ch = 8'h08;
      8'h66:   r.ch = 8'h0C;
      8'h6E:   r.ch = 8'h0A;
      8'h72:   r.ch = 8'h0D;
      8'h74:   r.ch = 8'h09;
      default: begin
        r.ok = 1'b0;
        r.ch = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic logic [2:0] word_len(input tok_class_e cls);
    logic [2:0] n;
    case (cls)
      TC_TRUE:  n = 3'd4;
      TC_FALSE: n = 3'd5;
      TC_NULL:  n = 3'd4;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] word_char(input tok_class_e cls, input logic [2:0] pos);
    logic [39:0] w;
    logic [7:0]  ch;
    case (cls)
      TC_TRUE:  w = WORD_TRUE;
      TC_FALSE: w = WORD_FALSE;
      TC_NULL:  w = WORD_NULL;
      default:  w = '0;
    endcase
    case (pos)
      3'd0:    ch = w[39:32];
      3'd1:    ch = w[31:24];
      3'd2:    ch = w[23:16];
      3'd3:    ch = w[15:8];
      3'd4:    ch = w[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/flat_json_object_parser_top.sv =====
// flat json object parser: takes a document one byte word at a time (kind 0) and
// checks that it forms a single object of "key": value pairs, where a value is a
// quoted string or a bare token (true, false, null or a run of decimal digits).
// every input word gives exactly one result word: decoded key and string bytes
// with escapes resolved, key end, value end (with type, boolean, 64-bit number
// and overflow flag), error, or none. the first error is reported once on the
// offending byte and then held; an end of document word (kind 1) reports
// acceptance, the held error or an error for an unfinished document, and re-arms the parser for the next document.
// throughput is one word per clock while the result side does not stall; a taken
// word is held in the input register, and its result is loaded into the result
// register, from which it is offered. the rate is set by the state update, whose
// longest path is the times-ten accumulate and overflow check of a digit token.
// a stall on the result side backs up into in_stall_o in the same cycle.
module flat_json_object_parser_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fjop_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fjop_pkg::out_word_t out_word_o
);
  import fjop_pkg::*;

  // input register
  logic        in_vld_q;
  in_word_t    in_word_q;
  // result register
  logic        out_vld_q;
  out_word_t   out_word_q;

  logic        fire;
  out_word_t   res;
  tok_cmd_e    tok_cmd;
  tok_status_t tok_status;

  // the held word is processed when the result register is free or draining
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  // parser state machine and per-byte decode
  fjop_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .word_i    (in_word_q),
    .tok_i     (tok_status),
    .tok_cmd_o (tok_cmd),
    .res_o     (res)
  );

  // bare token classifier and decimal accumulator
  fjop_token u_token (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (tok_cmd),
    .byte_i   (in_word_q.byte_in),
    .status_o (tok_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== hdl/fjop_token.sv =====
module fjop_token (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fjop_pkg::tok_cmd_e    cmd_i,
  input  logic [7:0]            byte_i,
  output fjop_pkg::tok_status_t status_o
);
  import fjop_pkg::*;

  tok_class_e       cls_q, cls_d, b_cls, n_cls;
  logic [2:0]       pos_q, pos_d, b_pos, n_pos;
  logic             space_q, space_d, b_space, n_space;
  logic [ACC_W-1:0] acc_q, acc_d, b_acc, n_acc;
  logic             ovf_q, ovf_d, b_ovf, n_ovf;
  logic [ACC_W+3:0] times_ten;
  logic [ACC_W-1:0] add_acc;
  logic             add_ovf;

  // a fresh token starts from the cleared state
  always_comb begin
    if (cmd_i == TOK_START) begin
      b_cls   = TC_NONE;
      b_pos   = '0;
      b_space = 1'b0;
      b_acc   = '0;
      b_ovf   = 1'b0;
    end else begin
      b_cls   = cls_q;
      b_pos   = pos_q;
      b_space = space_q;
      b_acc   = acc_q;
      b_ovf   = ovf_q;
    end
  end

  // acc * 10 + digit, saturating on overflow
  always_comb begin
    times_ten = ({4'b0, b_acc} << 3) + ({4'b0, b_acc} << 1)
              + {{ACC_W{1'b0}}, byte_i[3:0]};
    if (b_ovf) begin
      add_acc = b_acc;
      add_ovf = 1'b1;
    end else if (times_ten[ACC_W+3:ACC_W] != 4'd0) begin
      add_acc = '1;
      add_ovf = 1'b1;
    end else begin
      add_acc = times_ten[ACC_W-1:0];
      add_ovf = 1'b0;
    end
  end

  always_comb begin
    n_cls   = b_cls;
    n_pos   = b_pos;
    n_space = b_space;
    n_acc   = b_acc;
    n_ovf   = b_ovf;
    if (is_ws(byte_i)) begin
      n_space = 1'b1;
    end else if (b_space) begin
      n_cls = TC_BAD;
    end else begin
      case (b_cls)
        TC_NONE: begin
          n_pos = 3'd1;
          if (byte_i == 8'h74) begin
            n_cls = TC_TRUE;
          end else if (byte_i == 8'h66) begin
            n_cls = TC_FALSE;
          end else if (byte_i == 8'h6E) begin
            n_cls = TC_NULL;
          end else if (is_digit(byte_i)) begin
            n_cls = TC_DIGITS;
            n_acc = add_acc;
            n_ovf = add_ovf;
          end else begin
            n_cls = TC_BAD;
          end
        end
        TC_TRUE, TC_FALSE, TC_NULL: begin
          if (b_pos < word_len(b_cls) && byte_i == word_char(b_cls, b_pos)) begin
            n_pos = b_pos + 3'd1;
          end else begin
            n_cls = TC_BAD;
          end
        end
        TC_DIGITS: begin
          if (is_digit(byte_i)) begin
            n_acc = add_acc;
            n_ovf = add_ovf;
          end else begin
            n_cls = TC_BAD;
          end
        end
        default: n_cls = TC_BAD;
      endcase
    end
  end

  always_comb begin
    case (cmd_i)
      TOK_START, TOK_FEED: begin
        cls_d   = n_cls;
        pos_d   = n_pos;
        space_d = n_space;
        acc_d   = n_acc;
        ovf_d   = n_ovf;
      end
      TOK_CLEAR: begin
        cls_d   = TC_NONE;
        pos_d   = '0;
        space_d = 1'b0;
        acc_d   = '0;
        ovf_d   = 1'b0;
      end
      default: begin
        cls_d   = cls_q;
        pos_d   = pos_q;
        space_d = space_q;
        acc_d   = acc_q;
        ovf_d   = ovf_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q   <= TC_NONE;
      pos_q   <= '0;
      space_q <= 1'b0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      cls_q   <= cls_d;
      pos_q   <= pos_d;
      space_q <= space_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
    end
  end

  always_comb begin
    status_o.cls = cls_q;
    status_o.acc = acc_q;
    status_o.ovf = ovf_q;
    case (cls_q)
      TC_TRUE, TC_FALSE, TC_NULL: status_o.valid = (pos_q == word_len(cls_q));
      TC_DIGITS:                  status_o.valid = 1'b1;
      default:                    status_o.valid = 1'b0;
    endcase
  end

endmodule

// ===== hdl/fjop_ctrl.sv =====
module fjop_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  fjop_pkg::in_word_t    word_i,
  input  fjop_pkg::tok_status_t tok_i,
  output fjop_pkg::tok_cmd_e    tok_cmd_o,
  output fjop_pkg::out_word_t   res_o
);
  import fjop_pkg::*;

  phase_e     phase_q, phase_d;
  logic       esc_q, esc_d;
  err_e       sticky_q, sticky_d;
  err_e       fail_code;
  err_e       end_code;
  logic [7:0] c;
  logic       ws;
  logic       delim;
  esc_t       dec;

  assign c     = word_i.byte_in;
  assign ws    = is_ws(c);
  assign delim = (c == CH_COMMA) || (c == CH_RBRACE);
  assign dec   = esc_decode(c);

  // error raised by this byte, if any
  always_comb begin
    fail_code = ERR_NONE;
    if (!word_i.kind && sticky_q == ERR_NONE) begin
      case (phase_q)
        PH_OPEN:   if (!ws && c != CH_LBRACE) fail_code = ERR_MALFORMED;
        PH_FIRST:  if (!ws && c != CH_RBRACE && c != CH_QUOTE) fail_code = ERR_MALFORMED;
        PH_KEYQ:   if (!ws && c != CH_QUOTE) fail_code = ERR_MALFORMED;
        PH_KEY, PH_VSTR: begin
          if (esc_q) begin
            if (!dec.ok) fail_code = ERR_BAD_ESCAPE;
          end else if (c != CH_QUOTE && c < CH_SPACE) begin
            fail_code = ERR_CONTROL;
          end
        end
        PH_COLON:  if (!ws && c != CH_COLON) fail_code = ERR_MALFORMED;
        PH_VSTART: if (delim) fail_code = ERR_BAD_VALUE;
        PH_TOKEN:  if (delim && !tok_i.valid) fail_code = ERR_BAD_VALUE;
        PH_AFTER:  if (!ws && c != CH_RBRACE && c != CH_COMMA) fail_code = ERR_MALFORMED;
        PH_DONE:   if (!ws) fail_code = ERR_TRAILING;
        default:   fail_code = ERR_MALFORMED;
      endcase
    end
  end

  // verdict for an end of document word
  always_comb begin
    if (sticky_q != ERR_NONE) begin
      end_code = sticky_q;
    end else begin
      case (phase_q)
        PH_DONE:         end_code = ERR_NONE;
        PH_KEY, PH_VSTR: end_code = esc_q ? ERR_TRUNC_ESCAPE : ERR_UNTERMINATED;
        PH_VSTART:       end_code = ERR_MISSING_VALUE;
        PH_TOKEN:        end_code = tok_i.valid ? ERR_MALFORMED : ERR_BAD_VALUE;
        default:         end_code = ERR_MALFORMED;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    sticky_d = sticky_q;
    if (fire_i) begin
      if (word_i.kind) begin
        phase_d  = PH_OPEN;
        esc_d    = 1'b0;
        sticky_d = ERR_NONE;
      end else if (sticky_q != ERR_NONE) begin
        phase_d = phase_q;
      end else if (fail_code != ERR_NONE) begin
        sticky_d = fail_code;
        esc_d    = 1'b0;
      end else begin
        case (phase_q)
          PH_OPEN:  if (c == CH_LBRACE) phase_d = PH_FIRST;
          PH_FIRST: begin
            if (c == CH_RBRACE) phase_d = PH_DONE;
            else if (c == CH_QUOTE) phase_d = PH_KEY;
          end
          PH_KEYQ:  if (c == CH_QUOTE) phase_d = PH_KEY;
          PH_KEY, PH_VSTR: begin
            if (esc_q) begin
              esc_d = 1'b0;
            end else if (c == CH_QUOTE) begin
              phase_d = (phase_q == PH_KEY) ? PH_COLON : PH_AFTER;
            end else if (c == CH_BSLASH) begin
              esc_d = 1'b1;
            end
          end
          PH_COLON: if (c == CH_COLON) phase_d = PH_VSTART;
          PH_VSTART: begin
            if (c == CH_QUOTE) phase_d = PH_VSTR;
            else if (!ws) phase_d = PH_TOKEN;
          end
          PH_TOKEN: begin
            if (c == CH_RBRACE) phase_d = PH_DONE;
            else if (c == CH_COMMA) phase_d = PH_KEYQ;
          end
          PH_AFTER: begin
            if (c == CH_RBRACE) phase_d = PH_DONE;
            else if (c == CH_COMMA) phase_d = PH_KEYQ;
          end
          PH_DONE:  phase_d = PH_DONE;
          default:  phase_d = phase_q;
        endcase
      end
    end
  end

  // result word and token unit command
  always_comb begin
    res_o     = '0;
    tok_cmd_o = TOK_HOLD;
    if (fire_i) begin
      if (word_i.kind) begin
        tok_cmd_o = TOK_CLEAR;
        if (end_code == ERR_NONE) begin
          res_o.event_res = EV_ACCEPT;
        end else begin
          res_o.event_res  = EV_ERROR;
          res_o.error_code = end_code;
        end
      end else if (sticky_q != ERR_NONE) begin
        tok_cmd_o = TOK_HOLD;
      end else if (fail_code != ERR_NONE) begin
        res_o.event_res  = EV_ERROR;
        res_o.error_code = fail_code;
      end else begin
        case (phase_q)
          PH_FIRST, PH_AFTER: res_o.closes_object = (c == CH_RBRACE);
          PH_KEY, PH_VSTR: begin
            if (esc_q) begin
              res_o.event_res = (phase_q == PH_KEY) ? EV_KEY_BYTE : EV_STR_BYTE;
              res_o.char_out  = dec.ch;
            end else if (c == CH_QUOTE) begin
              res_o.event_res  = (phase_q == PH_KEY) ? EV_KEY_END : EV_VALUE_END;
              res_o.value_type = VT_STRING;
            end else if (c != CH_BSLASH) begin
              res_o.event_res = (phase_q == PH_KEY) ? EV_KEY_BYTE : EV_STR_BYTE;
              res_o.char_out  = c;
            end
          end
          PH_VSTART: if (!ws && c != CH_QUOTE) tok_cmd_o = TOK_START;
          PH_TOKEN: begin
            if (!delim) begin
              tok_cmd_o = TOK_FEED;
            end else begin
              tok_cmd_o           = TOK_CLEAR;
              res_o.event_res     = EV_VALUE_END;
              res_o.closes_object = (c == CH_RBRACE);
              case (tok_i.cls)
                TC_DIGITS: begin
                  res_o.value_type      = VT_NUMBER;
                  res_o.number_value    = tok_i.acc;
                  res_o.number_overflow = tok_i.ovf;
                end
                TC_NULL: res_o.value_type = VT_NULL;
                TC_TRUE: begin
                  res_o.value_type = VT_BOOL;
                  res_o.bool_value = 1'b1;
                end
                default: res_o.value_type = VT_BOOL;
              endcase
            end
          end
          default: tok_cmd_o = TOK_HOLD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_OPEN;
      esc_q    <= 1'b0;
      sticky_q <= ERR_NONE;
    end else begin
      phase_q  <= phase_d;
      esc_q    <= esc_d;
      sticky_q <= sticky_d;
    end
  end

endmodule

// ===== hdl/fjop_checker.sv =====
module fjop_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input fjop_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fjop_pkg::out_word_t out_word_o
);
  import fjop_pkg::*;

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o && (in_word_i.kind || !in_word_i.kind);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed under stall");

  // an accepted word taken while the result side is not stalled produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && !out_stall_i |=> ##1 out_valid_o)
    else $error("accepted word gave no result");

  // error code present exactly on error events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_word_o.event_res == EV_ERROR) == (out_word_o.error_code != 4'd0)))
    else $error("error code and event disagree");

  // closing brace only on a quiet byte or a value end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.closes_object |->
      out_word_o.event_res == EV_NONE || out_word_o.event_res == EV_VALUE_END)
    else $error("closing brace on unexpected event");

  // character field only carries key and string bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.event_res != EV_KEY_BYTE && out_word_o.event_res != EV_STR_BYTE
      |-> out_word_o.char_out == 8'h00)
    else $error("stray character on non-byte event");

endmodule

bind flat_json_object_parser_top fjop_checker u_checker (.*);
